// ----- src/bsfh_pkg.sv -----
`default_nettype none

package bsfh_pkg;

    // field widths
    localparam int BYTE_W = 8;
    localparam int POS_W  = 32;
    localparam int X_W    = POS_W + BYTE_W;
    localparam int WORD_W = 64;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // mixing constants
    localparam logic [63:0] GOLDEN_INIT   = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_A_INIT    = 64'hA24BAED4963EE407;
    localparam logic [63:0] MIX_B_CONST   = 64'h9FB21C651E98DF25;
    localparam logic [63:0] MIX_C_CONST   = 64'hC13FA9A902A6328F;
    localparam logic [63:0] MIX_D_INIT    = 64'h91E10DA5C79E7B1D;
    localparam logic [63:0] XOR_FEED      = 64'hD6E8FEB86659FD93;
    localparam logic [63:0] ADD_FEED      = 64'h94D049BB133111EB;
    localparam logic [63:0] FINAL_MUL_ONE = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] FINAL_MUL_TWO = 64'hC4CEB9FE1A85EC53;

    // one classified request handed from front to back
    typedef struct packed {
        logic [X_W-1:0]    x;
        logic [WORD_W-1:0] prod;
        logic              byte_valid;
        logic              is_last;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // avalanche step: shift-xor by 33
    function automatic logic [63:0] xs33(input logic [63:0] v);
        xs33 = v ^ {33'b0, v[63:33]};
    endfunction

    // rotate left by 7
    function automatic logic [63:0] rotl7(input logic [63:0] v);
        rotl7 = {v[56:0], v[63:57]};
    endfunction

endpackage

`default_nettype wire

// ----- src/byte_stream_fingerprint_hash.sv -----
`default_nettype none

// channel    direction  handshake             payload
// s_         in         s_tvalid / s_tready   s_tdata data_byte, s_tuser byte_valid, s_tlast is_last
// m_         out        m_tvalid / m_tready   m_tdata fingerprint
// apb        in         psel / penable        seed at byte address 0 (64 bits)
//
// in the front, the product of a message byte with the mixing constant is
// built from three partial products on one 32x32 multiplier
// the back folds each byte into the running state and avalanches it to finalize a message
// reset is synchronous, active low; seed resets to zero
// the queue lets the front keep taking bytes while the back finalizes or
// while the output register waits on m_tready
module byte_stream_fingerprint_hash #(
    parameter int QUEUE_DEPTH = bsfh_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] byte_valid
    input  wire logic        s_tlast,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [63:0] fingerprint
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    localparam logic REG_SEED = 1'b0;

    logic [63:0]      seed_reg;
    logic             seed_wr;
    logic             q_push, q_pop, q_full, q_empty;
    bsfh_pkg::entry_t q_wdata, q_rdata;

    // configuration register
    assign pready  = 1'b1;
    assign seed_wr = psel && penable && pwrite && (paddr[3] == REG_SEED);
    assign prdata  = (paddr[3] == REG_SEED) ? seed_reg : 64'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 64'b0;
        end else if (seed_wr) begin
            seed_reg <= pwdata;
        end
    end

    bsfh_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .restart    (seed_wr),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .data_byte  (s_tdata),
        .byte_valid (s_tuser),
        .is_last    (s_tlast),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    bsfh_queue #(
        .WIDTH (bsfh_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wdata),
        .pop     (q_pop),
        .rd_data (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    bsfh_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (seed_wr),
        .new_seed (pwdata),
        .seed     (seed_reg),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_data   (q_rdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- src/bsfh_mul.sv -----
`default_nettype none

// 64x64 multiply, low 64 bits, from three 32x32 partial products on one multiplier
module bsfh_mul (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] op_a,
    input  wire logic [63:0] op_b,
    output logic             done,
    output logic [63:0]      product
);

    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_HL = 2'd1;
    localparam logic [1:0] STEP_LH = 2'd2;
    localparam logic [1:0] STEP_SUM = 2'd3;

    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_out;

    // operand select for the shared multiplier
    always_comb begin
        mul_x   = (step_reg == STEP_HL) ? a_reg[63:32] : a_reg[31:0];
        mul_y   = (step_reg == STEP_LH) ? b_reg[63:32] : b_reg[31:0];
        mul_out = {32'b0, mul_x} * {32'b0, mul_y};
    end

    // step sequencer
    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = op_a;
            b_next    = op_b;
            step_next = STEP_LL;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            case (step_reg)
                STEP_LL: begin
                    prod_next = mul_out;
                    step_next = STEP_HL;
                end
                STEP_HL: begin
                    acc_next  = prod_reg;
                    prod_next = mul_out;
                    step_next = STEP_LH;
                end
                STEP_LH: begin
                    acc_next  = acc_reg + {prod_reg[31:0], 32'b0};
                    prod_next = mul_out;
                    step_next = STEP_SUM;
                end
                STEP_SUM: begin
                    acc_next  = acc_reg + {prod_reg[31:0], 32'b0};
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_LL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// ----- src/bsfh_queue.sv -----
`default_nettype none

// small register queue between front and back
module bsfh_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == DEPTH_C);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry write
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/bsfh_front.sv -----
`default_nettype none

// front: accepts requests, tracks byte position, precomputes the constant product
module bsfh_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       restart,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [bsfh_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                       byte_valid,
    input  wire logic                       is_last,
    input  wire logic                       q_full,
    output logic                            q_push,
    output bsfh_pkg::entry_t                q_data
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [bsfh_pkg::POS_W-1:0]    pos_reg, pos_next;
    bsfh_pkg::entry_t              ent_reg, ent_next;
    logic                          accept;
    logic [bsfh_pkg::X_W-1:0]      x_in;
    logic                          mul_start;
    logic                          mul_done;
    logic [63:0]                   mul_p;

    assign s_tready  = (state_reg == F_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign x_in      = {pos_reg, data_byte};
    assign mul_start = accept && byte_valid;
    assign q_push    = (state_reg == F_PUSH) && !q_full;
    assign q_data    = ent_reg;

    bsfh_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (bsfh_pkg::MIX_B_CONST),
        .op_b    ({24'b0, x_in[bsfh_pkg::X_W-1:1], 1'b1}),
        .done    (mul_done),
        .product (mul_p)
    );

    // classify and sequence
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        ent_next   = ent_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    ent_next.x          = x_in;
                    ent_next.byte_valid = byte_valid;
                    ent_next.is_last    = is_last;
                    if (byte_valid) begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = F_MUL;
                    end else if (is_last) begin
                        state_next = F_PUSH;
                    end
                    if (is_last) begin
                        pos_next = '0;
                    end
                end
            end
            F_MUL: begin
                if (mul_done) begin
                    ent_next.prod = mul_p;
                    state_next    = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!q_full) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
        if (restart) begin
            pos_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
        ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

// ----- src/bsfh_back.sv -----
`default_nettype none

// back: state recurrence, avalanche and the output register
module bsfh_back (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        restart,
    input  wire logic [63:0] new_seed,
    input  wire logic [63:0] seed,
    input  wire logic        q_empty,
    output logic             q_pop,
    input  wire bsfh_pkg::entry_t q_data,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MIXA = 3'd1;
    localparam logic [2:0] B_MIXB = 3'd2;
    localparam logic [2:0] B_MIXC = 3'd3;
    localparam logic [2:0] B_FIN  = 3'd4;
    localparam logic [2:0] B_MUL1 = 3'd5;
    localparam logic [2:0] B_MUL2 = 3'd6;
    localparam logic [2:0] B_OUT  = 3'd7;

    logic [2:0]       state_reg, state_next;
    bsfh_pkg::entry_t ent_reg, ent_next;
    logic [63:0]      rh_reg, rh_next;
    logic [63:0]      mx_reg, mx_next;
    logic [63:0]      ma_reg, ma_next;
    logic [63:0]      a_reg, a_next;
    logic [63:0]      b_reg, b_next;
    logic [63:0]      fin_reg, fin_next;
    logic             ovalid_reg, ovalid_next;
    logic [63:0]      odata_reg, odata_next;
    logic [63:0]      x64;
    logic             mul_start;
    logic [63:0]      mul_a, mul_b;
    logic             mul_done;
    logic [63:0]      mul_p;

    assign x64      = {24'b0, ent_reg.x};
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    bsfh_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // recurrence and finalize sequencer
    always_comb begin
        state_next  = state_reg;
        ent_next    = ent_reg;
        rh_next     = rh_reg;
        mx_next     = mx_reg;
        ma_next     = ma_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        fin_next    = fin_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        mul_start   = 1'b0;
        mul_a       = bsfh_pkg::xs33(rh_reg);
        mul_b       = bsfh_pkg::FINAL_MUL_ONE;
        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    ent_next   = q_data;
                    state_next = q_data.byte_valid ? B_MIXA : B_FIN;
                end
            end
            // two mixing terms
            B_MIXA: begin
                a_next     = (mx_reg ^ x64) + ent_reg.prod;
                b_next     = (bsfh_pkg::MIX_C_CONST + {x64[62:0], 1'b0})
                             ^ (ma_reg + {1'b0, x64[63:1]});
                state_next = B_MIXB;
            end
            // fold into the running hash and rotate
            B_MIXB: begin
                rh_next    = bsfh_pkg::rotl7(rh_reg ^ (a_reg + {b_reg[62:0], 1'b0}));
                state_next = B_MIXC;
            end
            // evolve the two mixing words
            B_MIXC: begin
                mx_next    = mx_reg ^ (rh_reg + bsfh_pkg::XOR_FEED);
                ma_next    = ma_reg + (rh_reg ^ bsfh_pkg::ADD_FEED);
                state_next = ent_reg.is_last ? B_FIN : B_IDLE;
            end
            B_FIN: begin
                mul_start  = 1'b1;
                state_next = B_MUL1;
            end
            B_MUL1: begin
                mul_a = bsfh_pkg::xs33(mul_p);
                mul_b = bsfh_pkg::FINAL_MUL_TWO;
                if (mul_done) begin
                    mul_start  = 1'b1;
                    state_next = B_MUL2;
                end
            end
            B_MUL2: begin
                if (mul_done) begin
                    fin_next   = bsfh_pkg::xs33(mul_p);
                    state_next = B_OUT;
                end
            end
            // hand off to the output register and restart from the seed
            B_OUT: begin
                if (!ovalid_reg || m_tready) begin
                    ovalid_next = 1'b1;
                    odata_next  = fin_reg;
                    rh_next     = seed ^ bsfh_pkg::GOLDEN_INIT;
                    mx_next     = bsfh_pkg::MIX_A_INIT;
                    ma_next     = bsfh_pkg::MIX_D_INIT;
                    state_next  = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
        if (restart) begin
            rh_next = new_seed ^ bsfh_pkg::GOLDEN_INIT;
            mx_next = bsfh_pkg::MIX_A_INIT;
            ma_next = bsfh_pkg::MIX_D_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= B_IDLE;
            ovalid_reg <= 1'b0;
            rh_reg     <= bsfh_pkg::GOLDEN_INIT;
            mx_reg     <= bsfh_pkg::MIX_A_INIT;
            ma_reg     <= bsfh_pkg::MIX_D_INIT;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            rh_reg     <= rh_next;
            mx_reg     <= mx_next;
            ma_reg     <= ma_next;
        end
        ent_reg   <= ent_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        fin_reg   <= fin_next;
        odata_reg <= odata_next;
    end

endmodule

`default_nettype wire

// ----- tb/bsfh_checker.sv -----
`timescale 1ns / 100ps

// watches both streams and the apb port, keeps its own copy of the hash state
// and checks every fingerprint against the oldest one still owed
module bsfh_checker #(
    parameter logic [3:0] SEED_ADDR = 4'd0
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] byte_valid
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,   // [63:0] fingerprint
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    input  wire logic [63:0] prdata,
    input  wire logic        pready,
    output int               mismatches,
    output int               fingerprints_due
);

    localparam logic [63:0] HASH_START = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] XOR_START  = 64'hA24BAED4963EE407;
    localparam logic [63:0] ADD_START  = 64'h91E10DA5C79E7B1D;
    localparam logic [63:0] BYTE_MUL   = 64'h9FB21C651E98DF25;
    localparam logic [63:0] BYTE_BIAS  = 64'hC13FA9A902A6328F;
    localparam logic [63:0] XOR_STIR   = 64'hD6E8FEB86659FD93;
    localparam logic [63:0] ADD_STIR   = 64'h94D049BB133111EB;
    localparam logic [63:0] AVAL_MUL_1 = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] AVAL_MUL_2 = 64'hC4CEB9FE1A85EC53;

    logic [63:0] seed_reg;
    logic [63:0] acc_hash;
    logic [63:0] xor_word;
    logic [63:0] add_word;
    logic [31:0] byte_pos;
    logic [63:0] fingerprint_q[$];

    // start a new message from the current seed
    function automatic void reload_from_seed();
        acc_hash = seed_reg ^ HASH_START;
        xor_word = XOR_START;
        add_word = ADD_START;
        byte_pos = 32'd0;
    endfunction

    // fold one message byte and its position into the running state
    function automatic void fold_byte(input logic [7:0] b);
        logic [63:0] x;
        logic [63:0] mix_a;
        logic [63:0] mix_b;
        logic [63:0] s;
        x     = {24'd0, byte_pos, b};
        mix_a = (xor_word ^ x) + BYTE_MUL * (x | 64'd1);
        mix_b = (BYTE_BIAS + (x << 1)) ^ (add_word + (x >> 1));
        s     = acc_hash ^ (mix_a + (mix_b << 1));
        s     = {s[56:0], s[63:57]};
        acc_hash = s;
        xor_word = xor_word ^ (s + XOR_STIR);
        add_word = add_word + (s ^ ADD_STIR);
        byte_pos = byte_pos + 32'd1;
    endfunction

    // 64-bit avalanche of the final state
    function automatic logic [63:0] avalanche(input logic [63:0] v);
        logic [63:0] s;
        s = v ^ (v >> 33);
        s = s * AVAL_MUL_1;
        s = s ^ (s >> 33);
        s = s * AVAL_MUL_2;
        s = s ^ (s >> 33);
        return s;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg = 64'd0;
            reload_from_seed();
            fingerprint_q.delete();
            mismatches = 0;
        end else begin
            // register access: a seed write restarts the message, a seed read is checked
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == SEED_ADDR) begin
                        seed_reg = pwdata;
                        reload_from_seed();
                    end
                end else if (paddr == SEED_ADDR && prdata !== seed_reg) begin
                    $error("seed readback mismatch: expected %h, actual %h", seed_reg, prdata);
                    mismatches++;
                end
            end

            // result request
            if (m_tvalid && m_tready) begin
                if (fingerprint_q.size() == 0) begin
                    $error("fingerprint: unexpected result %h", m_tdata);
                    mismatches++;
                end else if (m_tdata !== fingerprint_q[0]) begin
                    $error("fingerprint mismatch: expected %h, actual %h",
                           fingerprint_q[0], m_tdata);
                    mismatches++;
                    void'(fingerprint_q.pop_front());
                end else begin
                    void'(fingerprint_q.pop_front());
                end
            end

            // input request: absorb the byte first, then close the message
            if (s_tvalid && s_tready) begin
                if (s_tuser)
                    fold_byte(s_tdata);
                if (s_tlast) begin
                    fingerprint_q.push_back(avalanche(acc_hash));
                    reload_from_seed();
                end
            end
        end
        fingerprints_due = fingerprint_q.size();
    end

endmodule

// ----- tb/byte_stream_fingerprint_hash_tb.sv -----
`timescale 1ns / 100ps

module byte_stream_fingerprint_hash_tb;

    localparam logic [3:0] SEED_ADDR  = 4'd0;
    localparam logic [3:0] SPARE_ADDR = 4'd8;   // no register here
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASE_ITEMS   = 100;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;    // [7:0] data_byte
    logic        s_tuser  = 1'b0;    // [0] byte_valid
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;            // [63:0] fingerprint
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = 4'd0;
    logic [63:0] pwdata   = 64'd0;
    logic [63:0] prdata;
    logic        pready;

    int mismatches;
    int fingerprints_due;
    int items_sent = 0;
    bit calm = 1'b0;

    always #10 aclk = ~aclk;

    byte_stream_fingerprint_hash DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bsfh_checker #(
        .SEED_ADDR (SEED_ADDR)
    ) u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .mismatches       (mismatches),
        .fingerprints_due (fingerprints_due)
    );

    // result side back-pressure
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 14);
    end

    // one input request, with random gaps ahead of it unless calm; valid stays up afterwards
    task automatic send_req(input logic [7:0] b, input logic valid, input logic last);
        if (!calm) begin
            while ($urandom_range(99) < 14) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= valid;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (valid || last)
            items_sent++;
    endtask

    // message of random bytes, closed by the last byte or by an empty end request
    task automatic send_message(input int len, input bit empty_end);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 4)
                send_req(8'($urandom), 1'b0, 1'b0);
            send_req(8'($urandom), 1'b1, (i == len - 1) && !empty_end);
        end
        if (len == 0 || empty_end)
            send_req(8'($urandom), 1'b0, 1'b1);
    endtask

    // stop sending, wait for every owed fingerprint, then let the pipeline drain
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (fingerprints_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one apb transfer: setup then access
    task automatic apb_access(input logic wr, input logic [3:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [63:0] seed_val;
        int len;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty message, single-byte messages at the extremes
        send_req(8'hFF, 1'b0, 1'b1);
        send_req(8'h00, 1'b1, 1'b1);
        send_req(8'hFF, 1'b1, 1'b1);
        // ignored requests between bytes, closed by an empty end
        send_req(8'h3C, 1'b0, 1'b0);
        send_req(8'h01, 1'b1, 1'b0);
        send_req(8'hC3, 1'b0, 1'b0);
        send_req(8'h80, 1'b1, 1'b0);
        send_req(8'hAA, 1'b0, 1'b1);
        // two empty messages back to back
        send_req(8'h00, 1'b0, 1'b1);
        send_req(8'h55, 1'b0, 1'b1);
        send_req(8'h7F, 1'b1, 1'b0);
        send_req(8'hFE, 1'b1, 1'b1);
        settle();
        apb_access(1'b0, SEED_ADDR, 64'd0);

        // all-ones seed
        apb_access(1'b1, SEED_ADDR, {64{1'b1}});
        apb_access(1'b0, SEED_ADDR, 64'd0);
        send_req(8'h00, 1'b0, 1'b1);
        send_req(8'hFF, 1'b1, 1'b1);

        // write to an unused address mid-message: the message carries on
        send_req(8'h11, 1'b1, 1'b0);
        send_req(8'hEE, 1'b1, 1'b0);
        settle();
        apb_access(1'b1, SPARE_ADDR, {$urandom, $urandom});
        send_req(8'h5A, 1'b1, 1'b1);

        // seed write mid-message: the partial message is dropped
        send_req(8'hA5, 1'b1, 1'b0);
        send_req(8'h0F, 1'b1, 1'b0);
        settle();
        apb_access(1'b1, SEED_ADDR, 64'h8000_0000_0000_0001);
        send_req(8'hF0, 1'b1, 1'b1);
        settle();

        // random phases, each under its own seed
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: seed_val = {$urandom, $urandom};
                1: seed_val = 64'd0;
                2: seed_val = {64{1'b1}};
                default: seed_val = {$urandom, $urandom};
            endcase
            apb_access(1'b1, SEED_ADDR, seed_val);
            if ($urandom_range(1) == 1)
                apb_access(1'b0, SEED_ADDR, 64'd0);
            calm = (phase == 1);
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) begin
                if ($urandom_range(9) == 0)
                    len = $urandom_range(40, 13);
                else
                    len = $urandom_range(8, 0);
                send_message(len, $urandom_range(3) == 0);
            end
            // sometimes leave a message open so the next seed write drops it
            if (phase < 3 && $urandom_range(1) == 1) begin
                len = $urandom_range(5, 1);
                for (int i = 0; i < len; i++)
                    send_req(8'($urandom), 1'b1, 1'b0);
            end
            settle();
        end
        calm = 1'b0;

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
